### rtl/thread_sync_scheduler_core_defines.svh
// Assertion macros for the thread sync scheduler.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef THREAD_SYNC_SCHEDULER_CORE_DEFINES_SVH
`define THREAD_SYNC_SCHEDULER_CORE_DEFINES_SVH

`define TSS_ASSERT_ALWAYS(lbl, expr, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define TSS_ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/tss_pkg.sv
// Shared codes, default sizes and controller/datapath signal groups.
// No dependencies.
`default_nettype none
package tss_pkg;
    localparam int MAX_THREADS_DEF  = 16;
    localparam int OBJECT_COUNT_DEF = 32;

    localparam logic [2:0] OP_YIELD  = 3'd0;
    localparam logic [2:0] OP_FORK   = 3'd1;
    localparam logic [2:0] OP_LOCK   = 3'd2;
    localparam logic [2:0] OP_UNLOCK = 3'd3;
    localparam logic [2:0] OP_WAIT   = 3'd4;
    localparam logic [2:0] OP_SIGNAL = 3'd5;
    localparam logic [2:0] OP_BCAST  = 3'd6;
    localparam logic [2:0] OP_EXIT   = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_RELOCK   = 3'd2;
    localparam logic [2:0] ST_UNLOCK_NH = 3'd3;
    localparam logic [2:0] ST_WAIT_NH  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic clear;
        logic accept;
        logic load;
        logic exec;
        logic wr2;
        logic bc_read;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic is_bcast;
        logic need_wr2;
        logic bc_more;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

### rtl/tss_if.sv
// Request and response channel interfaces with valid/ready handshake.
// No dependencies.
`default_nettype none
interface tss_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [4:0] mutex_index;
    logic [4:0] cond_index;
    modport source (output valid, output opcode, output mutex_index, output cond_index,
                    input ready);
    modport sink   (input valid, input opcode, input mutex_index, input cond_index,
                    output ready);
endinterface

interface tss_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] running_thread;
    logic [3:0] forked_thread;
    logic       switched;
    modport source (output valid, output status, output running_thread,
                    output forked_thread, output switched, input ready);
    modport sink   (input valid, input status, input running_thread,
                    input forked_thread, input switched, output ready);
endinterface
`default_nettype wire

### rtl/thread_sync_scheduler_core.sv
// Thread sync scheduler top level: sequencer plus datapath.
// Each request: registered memory reads, execute, then the result register; a wait that
// hands off a lock while the ready list and condition queue are nonempty adds a second
// link write, and a broadcast walks its woken waiters before the result. No new request
// is taken before the last reaches the result register, and a result still held by the
// sink stalls the next request. Reset: synchronous, then clearing of the object memories.
`default_nettype none
module thread_sync_scheduler_core #(
    parameter int MAX_THREADS  = tss_pkg::MAX_THREADS_DEF,
    parameter int OBJECT_COUNT = tss_pkg::OBJECT_COUNT_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    tss_req_if.sink  i_req,
    tss_rsp_if.source o_rsp
);
    tss_pkg::t_cmd                  cmd;
    tss_pkg::t_stat                 stat;
    logic [$clog2(OBJECT_COUNT)-1:0] clr_idx;
    logic                           in_ready;

    tss_ctrl #(
        .OBJECT_COUNT(OBJECT_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_clr_idx  (clr_idx)
    );

    tss_dp #(
        .MAX_THREADS (MAX_THREADS),
        .OBJECT_COUNT(OBJECT_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_clr_idx        (clr_idx),
        .o_stat           (stat),
        .i_opcode         (i_req.opcode),
        .i_mutex_index    (i_req.mutex_index),
        .i_cond_index     (i_req.cond_index),
        .o_valid          (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_status         (o_rsp.status),
        .o_running_thread (o_rsp.running_thread),
        .o_forked_thread  (o_rsp.forked_thread),
        .o_switched       (o_rsp.switched)
    );

    assign i_req.ready = in_ready;
endmodule
`default_nettype wire

### rtl/tss_ctrl.sv
// Sequencer for the scheduler: clearing pass, load, execute, broadcast walk, result.
// Depends on tss_pkg.
`default_nettype none
module tss_ctrl #(
    parameter int OBJECT_COUNT = tss_pkg::OBJECT_COUNT_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  tss_pkg::t_stat                 i_stat,
    output tss_pkg::t_cmd                  o_cmd,
    output logic [$clog2(OBJECT_COUNT)-1:0] o_clr_idx
);
    localparam int OW = $clog2(OBJECT_COUNT);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;
    localparam logic [2:0] S_BCX  = 3'd5;
    localparam logic [2:0] S_BCR  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [OW-1:0] r_clr, n_clr;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clear = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == OW'(OBJECT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = i_stat.is_bcast ? S_BCX : S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_stat.need_wr2 ? S_WR2 : S_FIN;
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                n_state = S_FIN;
            end
            S_BCX: begin
                if (i_stat.bc_more) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_BCR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_BCR: begin
                o_cmd.bc_read = 1'b1;
                n_state = S_BCX;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_clr_idx  = r_clr;
endmodule
`default_nettype wire

### rtl/tss_dp.sv
// Datapath: ready queue, object and link memories, request execution, result register.
// Depends on tss_pkg and thread_sync_scheduler_core_defines.svh.
`default_nettype none
`include "thread_sync_scheduler_core_defines.svh"
module tss_dp #(
    parameter int MAX_THREADS  = tss_pkg::MAX_THREADS_DEF,
    parameter int OBJECT_COUNT = tss_pkg::OBJECT_COUNT_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  tss_pkg::t_cmd                   i_cmd,
    input  wire [$clog2(OBJECT_COUNT)-1:0]  i_clr_idx,
    output tss_pkg::t_stat                  o_stat,
    input  wire [2:0]                       i_opcode,
    input  wire [4:0]                       i_mutex_index,
    input  wire [4:0]                       i_cond_index,
    output logic                            o_valid,
    input  wire                             i_out_ready,
    output logic [2:0]                      o_status,
    output logic [3:0]                      o_running_thread,
    output logic [3:0]                      o_forked_thread,
    output logic                            o_switched
);
    localparam int TW = $clog2(MAX_THREADS);
    localparam int OW = $clog2(OBJECT_COUNT);
    localparam int NW = $clog2(MAX_THREADS + 1);
    localparam int MW = 3 * TW + 2;
    localparam int CW = 2 * TW + 1;
    localparam logic [10:0] OC11 = 11'(OBJECT_COUNT);

    logic [MW-1:0] mtx_mem [OBJECT_COUNT];
    logic [CW-1:0] cnd_mem [OBJECT_COUNT];
    logic [TW-1:0] lnk_mem [MAX_THREADS];
    logic [MW-1:0] mtx_rd;
    logic [CW-1:0] cnd_rd;
    logic [TW-1:0] lnk_rd;

    logic [OW-1:0] own_tab [MAX_THREADS];
    for (genvar g = 0; g < MAX_THREADS; g++) begin : g_own
        assign own_tab[g] = OW'(g % OBJECT_COUNT);
    end

    logic [2:0]    r_op;
    logic [OW-1:0] r_m, r_c;
    logic [TW-1:0] r_rh, r_rt, r_run, r_old, r_rlink;
    logic          r_rne;
    logic [NW-1:0] r_nfree;
    logic          r_m_held, r_mq_ne, r_cq_ne;
    logic [TW-1:0] r_m_holder, r_mq_h, r_mq_t, r_cq_h, r_cq_t;
    logic [2:0]    r_status;
    logic [TW-1:0] r_forked;
    logic [TW-1:0] r_w2_a, r_w2_d;
    logic          r_o_valid, r_o_sw;
    logic [2:0]    r_o_status;
    logic [3:0]    r_o_run, r_o_fk;

    // request index fold
    logic [10:0]   m11, c11, m_fold, c_fold;
    logic [OW-1:0] m_idx, c_idx, c_eff;
    always_comb begin
        m11    = {6'b0, i_mutex_index};
        c11    = {6'b0, i_cond_index};
        m_fold = (m11 >= OC11) ? (m11 - OC11) : m11;
        c_fold = (c11 >= OC11) ? (c11 - OC11) : c11;
        m_idx  = m_fold[OW-1:0];
        c_idx  = c_fold[OW-1:0];
        c_eff  = (i_opcode == tss_pkg::OP_EXIT) ? own_tab[r_run] : c_idx;
    end

    // execution of one request step
    logic [TW-1:0] rh, rt, rl, run, cur, w, fk;
    logic          rne, mh, mqne, cqne;
    logic [TW-1:0] mho, mqh, mqt, cqh, cqt;
    logic [NW-1:0] nf;
    logic [2:0]    st;
    logic          a_en, b_en;
    logic [TW-1:0] a_a, a_d, b_a, b_d;
    always_comb begin
        rh = r_rh; rt = r_rt; rne = r_rne; rl = r_rlink; run = r_run; cur = r_run;
        mh = r_m_held; mho = r_m_holder; mqh = r_mq_h; mqt = r_mq_t; mqne = r_mq_ne;
        cqh = r_cq_h; cqt = r_cq_t; cqne = r_cq_ne;
        nf = r_nfree; st = tss_pkg::ST_OK; fk = '0; w = '0;
        a_en = 1'b0; a_a = '0; a_d = '0;
        b_en = 1'b0; b_a = '0; b_d = '0;
        case (r_op)
            tss_pkg::OP_YIELD: begin
                if (rne) begin
                    a_en = 1'b1; a_a = rt; a_d = cur;
                    if (rt == rh) rl = cur;
                    rt = cur;
                end else begin
                    rh = cur; rt = cur; rne = 1'b1;
                end
                run = rh;
                if (rh == rt) rne = 1'b0;
                else rh = rl;
            end
            tss_pkg::OP_FORK: begin
                if (r_nfree >= NW'(MAX_THREADS)) begin
                    st = tss_pkg::ST_FULL;
                end else begin
                    nf = r_nfree + 1'b1;
                    if (rne) begin
                        a_en = 1'b1; a_a = rt; a_d = cur;
                        rt = cur;
                    end else begin
                        rh = cur; rt = cur; rne = 1'b1;
                    end
                    run = r_nfree[TW-1:0];
                    fk  = r_nfree[TW-1:0];
                end
            end
            tss_pkg::OP_LOCK: begin
                if (!mh) begin
                    mh = 1'b1; mho = cur;
                end else if (mho == cur) begin
                    st = tss_pkg::ST_RELOCK;
                end else if (!rne) begin
                    st = tss_pkg::ST_EMPTY;
                end else begin
                    if (mqne) begin
                        b_en = 1'b1; b_a = mqt; b_d = cur;
                        mqt = cur;
                    end else begin
                        mqh = cur; mqt = cur; mqne = 1'b1;
                    end
                    run = rh;
                    if (rh == rt) rne = 1'b0;
                    else rh = rl;
                end
            end
            tss_pkg::OP_UNLOCK, tss_pkg::OP_WAIT: begin
                if (!mh || mho != cur) begin
                    st = (r_op == tss_pkg::OP_UNLOCK) ? tss_pkg::ST_UNLOCK_NH
                                                       : tss_pkg::ST_WAIT_NH;
                end else if (r_op == tss_pkg::OP_WAIT && !rne && !mqne) begin
                    st = tss_pkg::ST_EMPTY;
                end else begin
                    if (!mqne) begin
                        mh = 1'b0; mho = '0;
                    end else begin
                        w = mqh;
                        if (mqh == mqt) mqne = 1'b0;
                        else mqh = lnk_rd;
                        if (rne) begin
                            a_en = 1'b1; a_a = rt; a_d = w;
                            if (rt == rh) rl = w;
                            rt = w;
                        end else begin
                            rh = w; rt = w; rne = 1'b1;
                        end
                        mho = w;
                    end
                    if (r_op == tss_pkg::OP_WAIT) begin
                        if (cqne) begin
                            b_en = 1'b1; b_a = cqt; b_d = cur;
                            cqt = cur;
                        end else begin
                            cqh = cur; cqt = cur; cqne = 1'b1;
                        end
                        run = rh;
                        if (rh == rt) rne = 1'b0;
                        else rh = rl;
                    end
                end
            end
            default: begin
                // signal, broadcast step and exit
                if (r_op == tss_pkg::OP_EXIT && !rne && !cqne) begin
                    st = tss_pkg::ST_EMPTY;
                end else begin
                    if (cqne) begin
                        w = cqh;
                        if (cqh == cqt) cqne = 1'b0;
                        else cqh = lnk_rd;
                        if (rne) begin
                            a_en = 1'b1; a_a = rt; a_d = w;
                            if (rt == rh) rl = w;
                            rt = w;
                        end else begin
                            rh = w; rt = w; rne = 1'b1;
                        end
                    end
                    if (r_op == tss_pkg::OP_EXIT) begin
                        run = rh;
                        if (rh == rt) rne = 1'b0;
                        else rh = rl;
                    end
                end
            end
        endcase
    end

    // memory ports
    logic          lnk_we;
    logic [TW-1:0] lnk_wa, lnk_wd, lnk_ra;
    always_comb begin
        lnk_we = 1'b0; lnk_wa = a_a; lnk_wd = a_d;
        if (i_cmd.wr2) begin
            lnk_we = 1'b1; lnk_wa = r_w2_a; lnk_wd = r_w2_d;
        end else if (i_cmd.exec) begin
            lnk_we = a_en | b_en;
            lnk_wa = a_en ? a_a : b_a;
            lnk_wd = a_en ? a_d : b_d;
        end
        if (i_cmd.load) begin
            lnk_ra = (r_op == tss_pkg::OP_UNLOCK || r_op == tss_pkg::OP_WAIT)
                   ? mtx_rd[2*TW:TW+1] : cnd_rd[2*TW:TW+1];
        end else if (i_cmd.bc_read) begin
            lnk_ra = r_cq_h;
        end else begin
            lnk_ra = r_rh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mtx_mem[i_clr_idx] <= '0;
            cnd_mem[i_clr_idx] <= '0;
        end else if (i_cmd.exec) begin
            mtx_mem[r_m] <= {mh, mho, mqh, mqt, mqne};
            cnd_mem[r_c] <= {cqh, cqt, cqne};
        end
        if (lnk_we) begin
            lnk_mem[lnk_wa] <= lnk_wd;
        end
        mtx_rd <= mtx_mem[m_idx];
        cnd_rd <= cnd_mem[c_eff];
        lnk_rd <= lnk_mem[lnk_ra];
    end

    // step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rh    <= '0;
            r_rt    <= '0;
            r_rne   <= 1'b0;
            r_run   <= '0;
            r_nfree <= NW'(1);
        end else if (i_cmd.exec) begin
            r_rh    <= rh;
            r_rt    <= rt;
            r_rne   <= rne;
            r_run   <= run;
            r_nfree <= nf;
        end
        if (i_cmd.accept) begin
            r_op     <= i_opcode;
            r_m      <= m_idx;
            r_c      <= c_eff;
            r_old    <= r_run;
            r_status <= tss_pkg::ST_OK;
            r_forked <= '0;
        end
        if (i_cmd.load) begin
            r_rlink    <= lnk_rd;
            r_m_held   <= mtx_rd[MW-1];
            r_m_holder <= mtx_rd[MW-2:2*TW+1];
            r_mq_h     <= mtx_rd[2*TW:TW+1];
            r_mq_t     <= mtx_rd[TW:1];
            r_mq_ne    <= mtx_rd[0];
            r_cq_h     <= cnd_rd[2*TW:TW+1];
            r_cq_t     <= cnd_rd[TW:1];
            r_cq_ne    <= cnd_rd[0];
        end
        if (i_cmd.exec) begin
            r_m_held   <= mh;
            r_m_holder <= mho;
            r_mq_h     <= mqh;
            r_mq_t     <= mqt;
            r_mq_ne    <= mqne;
            r_cq_h     <= cqh;
            r_cq_t     <= cqt;
            r_cq_ne    <= cqne;
            r_status   <= st;
            r_forked   <= fk;
            r_w2_a     <= b_a;
            r_w2_d     <= b_d;
        end
    end

    // result register
    logic [TW+3:0] run_ext, fk_ext;
    assign run_ext = {4'b0, r_run};
    assign fk_ext  = {4'b0, r_forked};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.fin) begin
            r_o_status <= r_status;
            r_o_run    <= run_ext[3:0];
            r_o_fk     <= fk_ext[3:0];
            r_o_sw     <= (r_run != r_old);
        end
    end

    assign o_stat.is_bcast = (r_op == tss_pkg::OP_BCAST);
    assign o_stat.need_wr2 = a_en & b_en;
    assign o_stat.bc_more  = r_cq_ne;
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_running_thread = r_o_run;
    assign o_forked_thread  = r_o_fk;
    assign o_switched       = r_o_sw;

    `TSS_ASSERT_IMPL(a_wr2_after_exec, i_cmd.wr2, $past(i_cmd.exec), "second link write without execute")
    `TSS_ASSERT_IMPL(a_switch_ok, r_o_valid && r_o_sw, r_o_status == tss_pkg::ST_OK, "switch on error")
    `TSS_ASSERT_ALWAYS(a_nfree_range, r_nfree <= NW'(MAX_THREADS), "free slot past table")
endmodule
`default_nettype wire

### bench/tss_checker.sv
// Scoreboard for the thread sync scheduler: watches request and response transfers,
// predicts each response and compares it field by field.
// Depends on tss_pkg and the interfaces in tss_if.sv.
`timescale 1ns / 100ps
`default_nettype none
module tss_checker (
    input  wire i_clk,
    input  wire i_rst_n,
    tss_req_if  i_req,
    tss_rsp_if  i_rsp,
    output int  o_fail_count,
    output int  o_pending
);
    localparam int NTHR = tss_pkg::MAX_THREADS_DEF;
    localparam int NOBJ = tss_pkg::OBJECT_COUNT_DEF;
    // queue slot 0 is the ready list, then one per mutex, then one per condition
    localparam int RDYQ = 0;
    localparam int MXQ  = 1;
    localparam int CVQ  = 1 + NOBJ;
    localparam int NQ   = 1 + 2 * NOBJ;

    localparam logic [2:0] TH_UNUSED  = 3'd0;
    localparam logic [2:0] TH_RUNNING = 3'd1;
    localparam logic [2:0] TH_READY   = 3'd2;
    localparam logic [2:0] TH_BLOCKED = 3'd3;
    localparam logic [2:0] TH_DONE    = 3'd4;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] running_thread;
        logic [3:0] forked_thread;
        logic       switched;
    } t_outcome;

    logic [2:0] thr_state [NTHR];
    logic [3:0] successor [NTHR];
    logic [3:0] q_head [NQ];
    logic [3:0] q_tail [NQ];
    logic       q_busy [NQ];
    logic       mx_held [NOBJ];
    logic [3:0] mx_owner [NOBJ];
    logic [3:0] cur_thread;
    logic [4:0] free_slot;
    t_outcome   awaited[$];

    initial begin
        for (int i = 0; i < NTHR; i++) begin
            thr_state[i] = TH_UNUSED;
            successor[i] = '0;
        end
        for (int i = 0; i < NQ; i++) begin
            q_head[i] = '0;
            q_tail[i] = '0;
            q_busy[i] = 1'b0;
        end
        for (int i = 0; i < NOBJ; i++) begin
            mx_held[i]  = 1'b0;
            mx_owner[i] = '0;
        end
        thr_state[0] = TH_RUNNING;
        cur_thread   = '0;
        free_slot    = 5'd1;
    end

    function automatic void enqueue(int q, logic [3:0] t);
        if (q_busy[q]) begin
            successor[q_tail[q]] = t;
            q_tail[q] = t;
        end else begin
            q_head[q] = t;
            q_tail[q] = t;
            q_busy[q] = 1'b1;
        end
    endfunction

    function automatic logic [3:0] dequeue(int q);
        logic [3:0] t;
        t = q_head[q];
        if (q_head[q] == q_tail[q]) q_busy[q] = 1'b0;
        else q_head[q] = successor[t];
        return t;
    endfunction

    function automatic void make_ready(logic [3:0] t);
        thr_state[t] = TH_READY;
        enqueue(RDYQ, t);
    endfunction

    function automatic void dispatch_next();
        logic [3:0] t;
        t = dequeue(RDYQ);
        thr_state[t] = TH_RUNNING;
        cur_thread = t;
    endfunction

    function automatic void wake_waiter(int c);
        if (q_busy[CVQ + c]) make_ready(dequeue(CVQ + c));
    endfunction

    function automatic void hand_off(int m);
        logic [3:0] w;
        if (!q_busy[MXQ + m]) begin
            mx_held[m]  = 1'b0;
            mx_owner[m] = '0;
        end else begin
            w = dequeue(MXQ + m);
            make_ready(w);
            mx_owner[m] = w;
        end
    endfunction

    function automatic t_outcome schedule_step(logic [2:0] op, logic [4:0] m, logic [4:0] c);
        t_outcome   r;
        logic [3:0] prev_run;
        prev_run = cur_thread;
        r = '0;
        r.status = tss_pkg::ST_OK;
        case (op)
            tss_pkg::OP_YIELD: begin
                make_ready(cur_thread);
                dispatch_next();
            end
            tss_pkg::OP_FORK: begin
                if (free_slot >= NTHR) begin
                    r.status = tss_pkg::ST_FULL;
                end else begin
                    make_ready(cur_thread);
                    cur_thread = free_slot[3:0];
                    thr_state[cur_thread] = TH_RUNNING;
                    r.forked_thread = free_slot[3:0];
                    free_slot++;
                end
            end
            tss_pkg::OP_LOCK: begin
                if (!mx_held[m]) begin
                    mx_held[m]  = 1'b1;
                    mx_owner[m] = cur_thread;
                end else if (mx_owner[m] == cur_thread) begin
                    r.status = tss_pkg::ST_RELOCK;
                end else if (!q_busy[RDYQ]) begin
                    r.status = tss_pkg::ST_EMPTY;
                end else begin
                    thr_state[cur_thread] = TH_BLOCKED;
                    enqueue(MXQ + m, cur_thread);
                    dispatch_next();
                end
            end
            tss_pkg::OP_UNLOCK: begin
                if (!mx_held[m] || mx_owner[m] != cur_thread) r.status = tss_pkg::ST_UNLOCK_NH;
                else hand_off(m);
            end
            tss_pkg::OP_WAIT: begin
                if (!mx_held[m] || mx_owner[m] != cur_thread) begin
                    r.status = tss_pkg::ST_WAIT_NH;
                end else if (!q_busy[RDYQ] && !q_busy[MXQ + m]) begin
                    r.status = tss_pkg::ST_EMPTY;
                end else begin
                    hand_off(m);
                    thr_state[cur_thread] = TH_BLOCKED;
                    enqueue(CVQ + c, cur_thread);
                    dispatch_next();
                end
            end
            tss_pkg::OP_SIGNAL: wake_waiter(c);
            tss_pkg::OP_BCAST: begin
                for (int i = 0; i < NTHR; i++)
                    if (q_busy[CVQ + c]) wake_waiter(c);
            end
            default: begin
                if (!q_busy[RDYQ] && !q_busy[CVQ + int'(cur_thread)]) begin
                    r.status = tss_pkg::ST_EMPTY;
                end else begin
                    wake_waiter(int'(cur_thread));
                    thr_state[cur_thread] = TH_DONE;
                    dispatch_next();
                end
            end
        endcase
        r.running_thread = cur_thread;
        r.switched = (cur_thread != prev_run);
        return r;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            o_fail_count = 0;
        end else begin
            if (i_req.valid && i_req.ready)
                awaited.push_back(schedule_step(i_req.opcode, i_req.mutex_index,
                                                i_req.cond_index));
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited.size() == 0) begin
                    $display("%0t: response with none expected, actual status %0d run %0d",
                             $time, i_rsp.status, i_rsp.running_thread);
                    o_fail_count++;
                end else begin
                    e = awaited.pop_front();
                    check_field("status", e.status, i_rsp.status);
                    check_field("running_thread", e.running_thread, i_rsp.running_thread);
                    check_field("forked_thread", e.forked_thread, i_rsp.forked_thread);
                    check_field("switched", e.switched, i_rsp.switched);
                end
            end
        end
        o_pending = awaited.size();
    end
endmodule
`default_nettype wire

### bench/tb_thread_sync_scheduler_core.sv
// Top of the thread sync scheduler bench: clock, reset, request stimulus and
// response back-pressure, verdict. Depends on tss_pkg, tss_if.sv and tss_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_thread_sync_scheduler_core;
    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;

    tss_req_if req_ch ();
    tss_rsp_if rsp_ch ();

    thread_sync_scheduler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tss_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= calm || ($urandom_range(99) >= 38);
        end
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic issue(logic [2:0] op, logic [4:0] m, logic [4:0] c);
        if (!calm && $urandom_range(99) < 38) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.mutex_index <= m;
        req_ch.cond_index  <= c;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [4:0] pick_object();
        return ($urandom_range(99) < 80) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
    endfunction

    function automatic logic [2:0] pick_op();
        int w;
        w = $urandom_range(99);
        if (w < 15) return tss_pkg::OP_YIELD;
        if (w < 23) return tss_pkg::OP_FORK;
        if (w < 43) return tss_pkg::OP_LOCK;
        if (w < 63) return tss_pkg::OP_UNLOCK;
        if (w < 75) return tss_pkg::OP_WAIT;
        if (w < 85) return tss_pkg::OP_SIGNAL;
        if (w < 93) return tss_pkg::OP_BCAST;
        return tss_pkg::OP_EXIT;
    endfunction

    initial begin
        i_rst_n            = 1'b0;
        calm               = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = tss_pkg::OP_YIELD;
        req_ch.mutex_index = '0;
        req_ch.cond_index  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(tss_pkg::OP_YIELD, 5'd0, 5'd0);
        issue(tss_pkg::OP_EXIT, 5'd0, 5'd0);
        issue(tss_pkg::OP_LOCK, 5'd31, 5'd0);
        issue(tss_pkg::OP_LOCK, 5'd31, 5'd0);
        issue(tss_pkg::OP_WAIT, 5'd31, 5'd31);
        issue(tss_pkg::OP_UNLOCK, 5'd31, 5'd0);
        issue(tss_pkg::OP_UNLOCK, 5'd31, 5'd0);
        issue(tss_pkg::OP_WAIT, 5'd5, 5'd0);
        issue(tss_pkg::OP_SIGNAL, 5'd0, 5'd31);
        issue(tss_pkg::OP_BCAST, 5'd0, 5'd10);
        issue(tss_pkg::OP_LOCK, 5'd1, 5'd0);
        issue(tss_pkg::OP_FORK, 5'd0, 5'd0);
        issue(tss_pkg::OP_LOCK, 5'd1, 5'd0);
        issue(tss_pkg::OP_FORK, 5'd0, 5'd0);
        issue(tss_pkg::OP_UNLOCK, 5'd1, 5'd0);
        issue(tss_pkg::OP_LOCK, 5'd1, 5'd0);
        issue(tss_pkg::OP_WAIT, 5'd1, 5'd21);
        issue(tss_pkg::OP_LOCK, 5'd2, 5'd0);
        issue(tss_pkg::OP_WAIT, 5'd2, 5'd21);
        issue(tss_pkg::OP_YIELD, 5'd0, 5'd0);
        issue(tss_pkg::OP_BCAST, 5'd0, 5'd21);
        issue(tss_pkg::OP_SIGNAL, 5'd0, 5'd21);
        issue(tss_pkg::OP_EXIT, 5'd0, 5'd0);
        issue(tss_pkg::OP_YIELD, 5'd0, 5'd0);

        for (int n = 0; n < 1900; n++) begin
            calm <= (n >= 700 && n < 1000);
            issue(pick_op(), pick_object(), pick_object());
        end
        req_ch.valid <= 1'b0;
        calm <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
